/* rtl/core/telegraph_shift_code_encoder_top_assert.svh */
`ifndef TELEGRAPH_SHIFT_CODE_ENCODER_TOP_ASSERT_SVH
`define TELEGRAPH_SHIFT_CODE_ENCODER_TOP_ASSERT_SVH
// concurrent check macros, clocked on clk with async reset
`define TSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* rtl/core/tsce_pkg.sv */
package tsce_pkg;

    localparam logic [7:0] SHIFT_LATIN    = 8'h0E;
    localparam logic [7:0] SHIFT_CYRILLIC = 8'h0F;
    localparam logic [7:0] CODE_SPACE     = 8'h20;
    localparam logic [7:0] CODE_CR        = 8'h0D;
    localparam logic [7:0] CODE_LF        = 8'h0A;
    localparam logic [7:0] CODE_BEL       = 8'h07;
    localparam logic [7:0] CODE_UNMAPPED  = 8'hFF;
    localparam logic       BANK_LATIN     = 1'b0;
    localparam logic       BANK_CYRILLIC  = 1'b1;
    localparam int         QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [15:0] char_code;
        logic        start_of_message;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } out_word_t;

    // classified character: keep_bank means keep current bank
    typedef struct packed {
        logic [7:0] code;
        logic       bank;
        logic       keep_bank;
        logic       start_of_message;
    } class_t;

    function automatic logic [7:0] cyr_lower(input logic [4:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                5'd0: r = 8'h41;  5'd1: r = 8'h42;  5'd2: r = 8'h57;  5'd3: r = 8'h47;
                5'd4: r = 8'h44;  5'd5: r = 8'h45;  5'd6: r = 8'h56;  5'd7: r = 8'h5A;
                5'd8: r = 8'h49;  5'd9: r = 8'h4A;  5'd10: r = 8'h4B; 5'd11: r = 8'h4C;
                5'd12: r = 8'h4D; 5'd13: r = 8'h4E; 5'd14: r = 8'h4F; 5'd15: r = 8'h50;
                5'd16: r = 8'h52; 5'd17: r = 8'h53; 5'd18: r = 8'h54; 5'd19: r = 8'h55;
                5'd20: r = 8'h46; 5'd21: r = 8'h48; 5'd22: r = 8'h43; 5'd23: r = 8'h5E;
                5'd24: r = 8'h5B; 5'd25: r = 8'h5D; 5'd26: r = 8'h00; 5'd27: r = 8'h59;
                5'd28: r = 8'h58; 5'd29: r = 8'h5C; 5'd30: r = 8'h40; 5'd31: r = 8'h51;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] latin_code(input logic [15:0] c);
        logic [7:0] r;
        begin
            r = 8'h00;
            if (c[15:8] == 8'h00) begin
                if ((c >= 16'h30 && c <= 16'h39) || (c >= 16'h41 && c <= 16'h5A) ||
                    (c >= 16'h61 && c <= 16'h7A))
                    r = c[7:0];
                else begin
                    case (c[7:0])
                        8'h22, 8'h23, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B,
                        8'h2D, 8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5D,
                        8'h5E, 8'h5F: r = c[7:0];
                        8'h60: r = 8'h3B;
                        8'h2E: r = 8'h7E;
                        8'h5C: r = 8'h60;
                        default: r = 8'h00;
                    endcase
                end
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] cyrillic_code(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] low;
        begin
            r = 8'h00;
            // both letter blocks start at an offset of 16 within their 32-code span
            low = cyr_lower(c[4:0] ^ 5'h10);
            if (c == 16'h21 || c == 16'h24)
                r = c[7:0];
            else if (c >= 16'h430 && c <= 16'h44F)
                r = low;
            else if (c >= 16'h410 && c <= 16'h42F)
                r = (low != 8'h00) ? low + 8'h20 : 8'h00;
            return r;
        end
    endfunction

endpackage

/* rtl/core/telegraph_shift_code_encoder_top.sv */
// path: an accepted input word passes the front register, the queue and the output register
// throughput: one word per cycle on output while out_stall is low; items needing no shift every cycle,
// items with a bank shift take two output words, one for the shift byte, one for the code
// a 2-entry queue between classifier and emitter lets each side stall on its own
// reset: asynchronous active-low, clears bank to latin and empties all stages
module telegraph_shift_code_encoder_top #(
    parameter int QUEUE_DEPTH = tsce_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsce_pkg::in_word_t  in_data,
    input  logic                in_valid,
    output logic                in_stall,
    output tsce_pkg::out_word_t out_data,
    output logic                out_valid,
    input  logic                out_stall
);

    tsce_pkg::class_t f_cls, q_cls;
    logic             f_valid, f_stall, q_valid, q_stall;

    tsce_front u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .cls(f_cls), .cls_valid(f_valid), .cls_stall(f_stall)
    );

    tsce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_cls), .wr_valid(f_valid),
        .wr_stall(f_stall), .rd_data(q_cls), .rd_valid(q_valid), .rd_stall(q_stall)
    );

    tsce_back u_back (
        .clk(clk), .rst_n(rst_n), .cls(q_cls), .cls_valid(q_valid), .cls_stall(q_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

endmodule

/* rtl/core/tsce_front.sv */
module tsce_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tsce_pkg::in_word_t in_data,
    input  logic              in_valid,
    output logic              in_stall,
    output tsce_pkg::class_t  cls,
    output logic              cls_valid,
    input  logic              cls_stall
);

    tsce_pkg::class_t cls_reg, cls_next;
    logic             valid_reg;
    logic [7:0]       lat;
    logic [7:0]       cyr;
    logic [15:0]      c;

    assign c   = in_data.char_code;
    assign lat = tsce_pkg::latin_code(c);
    assign cyr = tsce_pkg::cyrillic_code(c);

    always_comb
    begin
        cls_next.start_of_message = in_data.start_of_message;
        cls_next.keep_bank = 1'b1;
        cls_next.bank = tsce_pkg::BANK_LATIN;
        if (c == 16'h20)
            cls_next.code = tsce_pkg::CODE_SPACE;
        else if (c == 16'h0A)
            cls_next.code = tsce_pkg::CODE_LF;
        else if (c == 16'h0D)
            cls_next.code = tsce_pkg::CODE_CR;
        else if (c == 16'h07)
            cls_next.code = tsce_pkg::CODE_BEL;
        else
        begin
            cls_next.keep_bank = 1'b0;
            if (lat != 8'h00)
                cls_next.code = lat;
            else if (cyr != 8'h00)
            begin
                cls_next.code = cyr;
                cls_next.bank = tsce_pkg::BANK_CYRILLIC;
            end
            else
                cls_next.code = tsce_pkg::CODE_UNMAPPED;
        end
    end

    assign in_stall  = valid_reg && cls_stall;
    assign cls       = cls_reg;
    assign cls_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            cls_reg <= cls_next;
    end

endmodule

/* rtl/core/tsce_queue.sv */
`include "telegraph_shift_code_encoder_top_assert.svh"
module tsce_queue #(
    parameter int DEPTH = tsce_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tsce_pkg::class_t wr_data,
    input  logic             wr_valid,
    output logic             wr_stall,
    output tsce_pkg::class_t rd_data,
    output logic             rd_valid,
    input  logic             rd_stall
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tsce_pkg::class_t  mem_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr_en, rd_en;

    assign wr_stall = (cnt_reg == AW'(0) + (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    `TSC_ASSERT(a_cnt_bound, cnt_reg <= (AW+1)'(DEPTH), "queue count overflow")
    `TSC_ASSERT(a_empty_read, (cnt_reg == '0) |-> !rd_en, "read from empty queue")
    `TSC_ASSERT(a_full_write, (cnt_reg == (AW+1)'(DEPTH)) |=> (cnt_reg != '0), "full queue lost")

endmodule

/* rtl/core/tsce_back.sv */
`include "telegraph_shift_code_encoder_top_assert.svh"
module tsce_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tsce_pkg::class_t   cls,
    input  logic               cls_valid,
    output logic               cls_stall,
    output tsce_pkg::out_word_t out_data,
    output logic               out_valid,
    input  logic               out_stall
);

    logic       bank_reg;
    logic       shifted_reg;
    logic       eff_bank;
    logic       need_bank;
    logic       need_shift;
    logic       load;
    tsce_pkg::out_word_t word_reg, word_next;
    logic       valid_reg;

    assign eff_bank   = cls.start_of_message ? tsce_pkg::BANK_LATIN : bank_reg;
    assign need_bank  = cls.keep_bank ? eff_bank : cls.bank;
    // shift byte goes out first, then the code byte on the next slot
    assign need_shift = (need_bank != eff_bank) && !shifted_reg;
    assign load       = cls_valid && (!valid_reg || !out_stall);
    assign cls_stall  = !(load && !need_shift);

    always_comb
    begin
        if (need_shift)
            word_next = '{out_byte: (need_bank == tsce_pkg::BANK_CYRILLIC) ?
                          tsce_pkg::SHIFT_CYRILLIC : tsce_pkg::SHIFT_LATIN,
                          last_of_item: 1'b0};
        else
            word_next = '{out_byte: cls.code, last_of_item: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= tsce_pkg::BANK_LATIN;
            shifted_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                if (need_shift)
                    shifted_reg <= 1'b1;
                else
                begin
                    shifted_reg <= 1'b0;
                    bank_reg    <= need_bank;
                end
            end
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    assign out_data  = word_reg;
    assign out_valid = valid_reg;

    `TSC_ASSERT(a_shift_then_code, (load && need_shift) |=> shifted_reg, "shift not followed")
    `TSC_ASSERT(a_shift_last, (valid_reg && !word_reg.last_of_item) |-> shifted_reg,
        "shift byte without pending code")
    `TSC_ASSERT_NEVER(a_bank_moved, shifted_reg && !cls_valid, "lost item mid shift")

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] ch;
        logic        som;
        logic [7:0]  code;   // 0 means use the predictor
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    tsce_pkg::in_word_t  in_data;
    logic                in_valid;
    logic                in_stall;
    tsce_pkg::out_word_t out_data;
    logic                out_valid;
    logic                out_stall;

    telegraph_shift_code_encoder_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tsce_pkg::out_word_t pending_bytes[$];
    logic       model_bank;
    int         errors;
    int         idle_cycles;
    logic       stall_mode;
    int         stall_left;

    localparam int WATCHDOG = 2000;

    function automatic logic [7:0] russian_lower_code(input logic [4:0] i);
        logic [7:0] tbl [32];
        tbl = '{8'h41, 8'h42, 8'h57, 8'h47, 8'h44, 8'h45, 8'h56, 8'h5A,
                8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
                8'h52, 8'h53, 8'h54, 8'h55, 8'h46, 8'h48, 8'h43, 8'h5E,
                8'h5B, 8'h5D, 8'h00, 8'h59, 8'h58, 8'h5C, 8'h40, 8'h51};
        return tbl[i];
    endfunction

    // encode one character, append its bytes, update the bank
    task automatic encode_char(input logic [15:0] c, input logic som, input logic [7:0] want);
        logic [7:0] code;
        logic       bank;
        logic       keep;
        logic [4:0] idx;
        tsce_pkg::out_word_t w;
        keep = 1'b0;
        bank = tsce_pkg::BANK_LATIN;
        code = tsce_pkg::CODE_UNMAPPED;
        // letter index counted from the first letter of either block
        idx = c[4:0] ^ 5'h10;
        if (som)
            model_bank = tsce_pkg::BANK_LATIN;
        if (c == 16'h20 || c == 16'h0A || c == 16'h0D || c == 16'h07)
        begin
            keep = 1'b1;
            code = c[7:0];
        end
        else if ((c >= 16'h30 && c <= 16'h39) || (c >= 16'h41 && c <= 16'h5A)
                 || (c >= 16'h61 && c <= 16'h7A) || c == 16'h22 || c == 16'h23
                 || c == 16'h25 || c == 16'h26 || c == 16'h28 || c == 16'h29
                 || c == 16'h2A || c == 16'h2B || c == 16'h2D || c == 16'h2F
                 || (c >= 16'h3C && c <= 16'h3F) || c == 16'h5B || c == 16'h5D
                 || c == 16'h5E || c == 16'h5F)
            code = c[7:0];
        else if (c == 16'h60)
            code = 8'h3B;
        else if (c == 16'h2E)
            code = 8'h7E;
        else if (c == 16'h5C)
            code = 8'h60;
        else if (c == 16'h21 || c == 16'h24)
        begin
            code = c[7:0];
            bank = tsce_pkg::BANK_CYRILLIC;
        end
        else if (c >= 16'h410 && c <= 16'h44F && russian_lower_code(idx) != 8'h00)
        begin
            code = russian_lower_code(idx) + ((c < 16'h430) ? 8'h20 : 8'h00);
            bank = tsce_pkg::BANK_CYRILLIC;
        end
        if (want != 8'h00)
            code = want;
        if (keep)
            bank = model_bank;
        if (bank != model_bank)
        begin
            model_bank = bank;
            w.out_byte = (bank == tsce_pkg::BANK_CYRILLIC) ?
                         tsce_pkg::SHIFT_CYRILLIC : tsce_pkg::SHIFT_LATIN;
            w.last_of_item = 1'b0;
            pending_bytes.push_back(w);
        end
        w.out_byte = code;
        w.last_of_item = 1'b1;
        pending_bytes.push_back(w);
    endtask

    task automatic send_char(input logic [15:0] c, input logic som, input logic [7:0] want);
        in_data <= '{char_code: c, start_of_message: som};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_char(c, som, want);
    endtask

    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 5) == 0)
        begin
            g = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] random_char();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return 16'($urandom_range(16'h410, 16'h44F));
        else if (k < 6)
            return 16'($urandom_range(16'h20, 16'h7F));
        else if (k == 6)
            return 16'($urandom_range(0, 16'h1F));
        else if (k == 7)
            return 16'($urandom_range(16'h400, 16'h45F));
        else
            return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // receiver: alternate stall-heavy and stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= 1'($urandom_range(0, 1));
                stall_left <= $urandom_range(10, 80);
            end
            else
                stall_left <= stall_left - 1;
            out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected word out_byte=%h", out_data.out_byte);
                errors++;
            end
            else
            begin
                if (out_data.out_byte !== pending_bytes[0].out_byte)
                begin
                    $error("out_byte expected %h actual %h",
                           pending_bytes[0].out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.last_of_item !== pending_bytes[0].last_of_item)
                begin
                    $error("last_of_item expected %b actual %b",
                           pending_bytes[0].last_of_item, out_data.last_of_item);
                    errors++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    dir_row_t directed[] = '{
        '{16'h0041, 1'b1, 8'h41},
        '{16'h0000, 1'b0, 8'hFF},
        '{16'hFFFF, 1'b0, 8'hFF},
        '{16'h0020, 1'b0, 8'h20},
        '{16'h0430, 1'b0, 8'h41},
        '{16'h0020, 1'b0, 8'h20},
        '{16'h000A, 1'b0, 8'h0A},
        '{16'h000D, 1'b0, 8'h0D},
        '{16'h0007, 1'b0, 8'h07},
        '{16'h044F, 1'b0, 8'h51},
        '{16'h0410, 1'b0, 8'h61},
        '{16'h042F, 1'b0, 8'h00},
        '{16'h044A, 1'b0, 8'hFF},
        '{16'h0021, 1'b0, 8'h21},
        '{16'h0024, 1'b1, 8'h24},
        '{16'h0041, 1'b1, 8'h41},
        '{16'h0060, 1'b0, 8'h3B},
        '{16'h002E, 1'b0, 8'h7E},
        '{16'h005C, 1'b0, 8'h60},
        '{16'h007A, 1'b0, 8'h7A},
        '{16'h0430, 1'b0, 8'h41},
        '{16'h0020, 1'b1, 8'h20},
        '{16'h042A, 1'b0, 8'hFF},
        '{16'h8430, 1'b0, 8'hFF},
        '{16'h0030, 1'b0, 8'h30}
    };

    initial
    begin
        int n;
        int tail;
        errors = 0;
        idle_cycles = 0;
        model_bank = tsce_pkg::BANK_LATIN;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_char(directed[i].ch, directed[i].som, directed[i].code);

        for (n = 0; n < 1600; n++)
        begin
            maybe_gap();
            send_char(random_char(), $urandom_range(0, 15) == 0, 8'h00);
            if (n == 800)
            begin
                in_valid <= 1'b0;
                while (pending_bytes.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 20)
        begin
            @(posedge clk);
            tail++;
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
